/* src/report_frame_builder_crc16_defines.svh */
// assertion macros shared by the report frame builder modules
`ifndef REPORT_FRAME_BUILDER_CRC16_DEFINES_SVH
`define REPORT_FRAME_BUILDER_CRC16_DEFINES_SVH

// same-cycle implication, checked on clk, off while rst is high
`define RFB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk, off while rst is high
`define RFB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/rfb_pkg.sv */
// shared types, constants and the crc step for the report frame builder
package rfb_pkg;

  localparam int unsigned FrameLen = 21;
  localparam int unsigned PosW     = 5;
  localparam int unsigned AddrW    = 5;

  localparam logic [PosW-1:0] PosHdr0    = 5'd0;
  localparam logic [PosW-1:0] PosHdr1    = 5'd1;
  localparam logic [PosW-1:0] PosVersion = 5'd2;
  localparam logic [PosW-1:0] PosMsgType = 5'd3;
  localparam logic [PosW-1:0] PosPayLen  = 5'd4;
  localparam logic [PosW-1:0] PosSeq     = 5'd5;
  localparam logic [PosW-1:0] PosRaw0    = 5'd6;
  localparam logic [PosW-1:0] PosRaw1    = 5'd7;
  localparam logic [PosW-1:0] PosRaw2    = 5'd8;
  localparam logic [PosW-1:0] PosRaw3    = 5'd9;
  localparam logic [PosW-1:0] PosWgt0    = 5'd10;
  localparam logic [PosW-1:0] PosWgt1    = 5'd11;
  localparam logic [PosW-1:0] PosWgt2    = 5'd12;
  localparam logic [PosW-1:0] PosWgt3    = 5'd13;
  localparam logic [PosW-1:0] PosThr0    = 5'd14;
  localparam logic [PosW-1:0] PosThr1    = 5'd15;
  localparam logic [PosW-1:0] PosDevice  = 5'd16;
  localparam logic [PosW-1:0] PosCrcLo   = 5'd17;
  localparam logic [PosW-1:0] PosCrcHi   = 5'd18;
  localparam logic [PosW-1:0] PosTail0   = 5'd19;
  localparam logic [PosW-1:0] PosLast    = 5'd20;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  typedef enum logic [2:0] {
    REG_HEADER_FIRST     = 3'd0,
    REG_HEADER_SECOND    = 3'd1,
    REG_PROTOCOL_VERSION = 3'd2,
    REG_MESSAGE_TYPE     = 3'd3,
    REG_PAYLOAD_LENGTH   = 3'd4,
    REG_TAIL_FIRST       = 3'd5,
    REG_TAIL_SECOND      = 3'd6,
    REG_NONE             = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [7:0]         sequence_number;
    logic signed [31:0] raw_sample;
    logic [31:0]        weight_tenths;
    logic [15:0]        threshold_grams;
    logic [3:0]         device_type;
  } item_t;

  typedef struct packed {
    logic [7:0] header_first;
    logic [7:0] header_second;
    logic [7:0] protocol_version;
    logic [7:0] message_type;
    logic [7:0] payload_length;
    logic [7:0] tail_first;
    logic [7:0] tail_second;
  } cfg_t;

  typedef struct packed {
    logic can_load;
  } framer_status_t;

  // one byte through crc-16/modbus, lsb first
  function automatic logic [15:0] crc_byte(logic [15:0] crc_in, logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* src/rfb_ifs.sv */
// valid/ready channel interfaces for report items and frame bytes
interface rfb_item_if;
  logic               valid;
  logic               ready;
  logic [7:0]         sequence_number;
  logic signed [31:0] raw_sample;
  logic [31:0]        weight_tenths;
  logic [15:0]        threshold_grams;
  logic [3:0]         device_type;

  modport source (output valid, sequence_number, raw_sample, weight_tenths,
                  threshold_grams, device_type, input ready);
  modport sink (input valid, sequence_number, raw_sample, weight_tenths,
                threshold_grams, device_type, output ready);
endinterface

interface rfb_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic [4:0] byte_position;
  logic       last_byte;

  modport source (output valid, frame_byte, byte_position, last_byte, input ready);
  modport sink (input valid, frame_byte, byte_position, last_byte, output ready);
endinterface

/* src/rfb_framer.sv */
// frame serializer: one byte per cycle unless stalled, with a running crc, output register
`include "report_frame_builder_crc16_defines.svh"

module rfb_framer (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    load,
  input  rfb_pkg::item_t          item_d,
  input  rfb_pkg::cfg_t           cfg,
  output rfb_pkg::framer_status_t status,
  rfb_byte_if.source              result
);

  logic                       busy;
  logic [rfb_pkg::PosW-1:0]   pos;
  logic [15:0]                crc;
  logic [15:0]                crc_next;
  rfb_pkg::item_t             cur;
  logic                       out_valid;
  logic [7:0]                 out_byte;
  logic [rfb_pkg::PosW-1:0]   out_pos;
  logic                       out_last;
  logic                       out_adv;
  logic [7:0]                 cur_byte;
  logic                       in_crc;

  assign out_adv         = !out_valid || result.ready;
  assign status.can_load = !busy || (out_adv && (pos == rfb_pkg::PosLast));

  always_comb begin
    case (pos)
      rfb_pkg::PosHdr0:    cur_byte = cfg.header_first;
      rfb_pkg::PosHdr1:    cur_byte = cfg.header_second;
      rfb_pkg::PosVersion: cur_byte = cfg.protocol_version;
      rfb_pkg::PosMsgType: cur_byte = cfg.message_type;
      rfb_pkg::PosPayLen:  cur_byte = cfg.payload_length;
      rfb_pkg::PosSeq:     cur_byte = cur.sequence_number;
      rfb_pkg::PosRaw0:    cur_byte = cur.raw_sample[7:0];
      rfb_pkg::PosRaw1:    cur_byte = cur.raw_sample[15:8];
      rfb_pkg::PosRaw2:    cur_byte = cur.raw_sample[23:16];
      rfb_pkg::PosRaw3:    cur_byte = cur.raw_sample[31:24];
      rfb_pkg::PosWgt0:    cur_byte = cur.weight_tenths[7:0];
      rfb_pkg::PosWgt1:    cur_byte = cur.weight_tenths[15:8];
      rfb_pkg::PosWgt2:    cur_byte = cur.weight_tenths[23:16];
      rfb_pkg::PosWgt3:    cur_byte = cur.weight_tenths[31:24];
      rfb_pkg::PosThr0:    cur_byte = cur.threshold_grams[7:0];
      rfb_pkg::PosThr1:    cur_byte = cur.threshold_grams[15:8];
      rfb_pkg::PosDevice:  cur_byte = {4'h0, cur.device_type};
      rfb_pkg::PosCrcLo:   cur_byte = crc[7:0];
      rfb_pkg::PosCrcHi:   cur_byte = crc[15:8];
      rfb_pkg::PosTail0:   cur_byte = cfg.tail_first;
      rfb_pkg::PosLast:    cur_byte = cfg.tail_second;
      default:             cur_byte = 8'h00;
    endcase
  end

  // crc covers version through device code
  assign in_crc   = (pos >= rfb_pkg::PosVersion) && (pos <= rfb_pkg::PosDevice);
  assign crc_next = in_crc ? rfb_pkg::crc_byte(crc, cur_byte) : crc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_adv) begin
        out_valid <= busy;
      end
      if (load) begin
        busy <= 1'b1;
        pos  <= '0;
      end else if (busy && out_adv) begin
        pos <= pos + 1'b1;
        if (pos == rfb_pkg::PosLast) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && busy) begin
      out_byte <= cur_byte;
      out_pos  <= pos;
      out_last <= (pos == rfb_pkg::PosLast);
    end
    if (load) begin
      cur <= item_d;
      crc <= rfb_pkg::CrcInit;
    end else if (busy && out_adv) begin
      crc <= crc_next;
    end
  end

  assign result.valid         = out_valid;
  assign result.frame_byte    = out_byte;
  assign result.byte_position = out_pos;
  assign result.last_byte     = out_last;

  `RFB_ASSERT_SAME(a_pos_range, busy, pos <= rfb_pkg::PosLast, "frame position past end")
  `RFB_ASSERT_SAME(a_last_pos, out_valid, out_last == (out_pos == rfb_pkg::PosLast), "last flag off its position")
  `RFB_ASSERT_NEXT(a_pos_step, busy && out_adv && !load, out_valid && (out_pos == $past(pos)), "emitted position skipped")
  `RFB_ASSERT_SAME(a_load_ok, load, status.can_load, "frame loaded while serializer busy")

endmodule

/* src/report_frame_builder_crc16.sv */
// report frame builder top: config registers, input register, frame serializer
// a report taken into the input register moves to the serializer once it can load;
//   its first frame byte (position 0) is then registered in the output register
// the output register sends one frame byte per cycle while the receiver is ready;
//   the next report waits in the input register meanwhile
// reset (synchronous, active high) empties the input and output registers and
//   returns every config register to its default
`include "report_frame_builder_crc16_defines.svh"

module report_frame_builder_crc16 (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [rfb_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  rfb_item_if.sink                  item,
  rfb_byte_if.source                result
);

  // config register file
  rfb_pkg::cfg_t          cfg;
  rfb_pkg::reg_idx_t      reg_idx;
  logic                   cfg_write;

  // input register holding the next report
  logic                   hold_valid;
  rfb_pkg::item_t         hold;
  logic                   load;
  logic                   item_take;
  rfb_pkg::framer_status_t fstat;

  assign pready    = 1'b1;
  assign reg_idx   = rfb_pkg::reg_idx_t'(paddr[rfb_pkg::AddrW-1:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_first     <= 8'd0;
      cfg.header_second    <= 8'd0;
      cfg.protocol_version <= 8'd1;
      cfg.message_type     <= 8'd0;
      cfg.payload_length   <= 8'd11;
      cfg.tail_first       <= 8'd0;
      cfg.tail_second      <= 8'd0;
    end else if (cfg_write) begin
      // writes beyond the last register are dropped
      unique case (reg_idx)
        rfb_pkg::REG_HEADER_FIRST:     cfg.header_first     <= pwdata[7:0];
        rfb_pkg::REG_HEADER_SECOND:    cfg.header_second    <= pwdata[7:0];
        rfb_pkg::REG_PROTOCOL_VERSION: cfg.protocol_version <= pwdata[7:0];
        rfb_pkg::REG_MESSAGE_TYPE:     cfg.message_type     <= pwdata[7:0];
        rfb_pkg::REG_PAYLOAD_LENGTH:   cfg.payload_length   <= pwdata[7:0];
        rfb_pkg::REG_TAIL_FIRST:       cfg.tail_first       <= pwdata[7:0];
        rfb_pkg::REG_TAIL_SECOND:      cfg.tail_second      <= pwdata[7:0];
        rfb_pkg::REG_NONE:             ;
      endcase
    end
  end

  // read back, zero extended
  always_comb begin
    unique case (reg_idx)
      rfb_pkg::REG_HEADER_FIRST:     prdata = {24'h0, cfg.header_first};
      rfb_pkg::REG_HEADER_SECOND:    prdata = {24'h0, cfg.header_second};
      rfb_pkg::REG_PROTOCOL_VERSION: prdata = {24'h0, cfg.protocol_version};
      rfb_pkg::REG_MESSAGE_TYPE:     prdata = {24'h0, cfg.message_type};
      rfb_pkg::REG_PAYLOAD_LENGTH:   prdata = {24'h0, cfg.payload_length};
      rfb_pkg::REG_TAIL_FIRST:       prdata = {24'h0, cfg.tail_first};
      rfb_pkg::REG_TAIL_SECOND:      prdata = {24'h0, cfg.tail_second};
      rfb_pkg::REG_NONE:             prdata = 32'h0;
    endcase
  end

  // the input register frees up in the same cycle its report moves to the
  // serializer, so a new transaction is taken while the last frame drains
  assign load       = hold_valid && fstat.can_load;
  assign item.ready = !hold_valid || load;
  assign item_take  = item.valid && item.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (item_take) begin
      hold_valid <= 1'b1;
    end else if (load) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      hold.sequence_number <= item.sequence_number;
      hold.raw_sample      <= item.raw_sample;
      hold.weight_tenths   <= item.weight_tenths;
      hold.threshold_grams <= item.threshold_grams;
      hold.device_type     <= item.device_type;
    end
  end

  // serializer: header, fields, crc and tail, one byte per output transaction
  rfb_framer u_framer (
    .clk    (clk),
    .rst    (rst),
    .load   (load),
    .item_d (hold),
    .cfg    (cfg),
    .status (fstat),
    .result (result)
  );

  `RFB_ASSERT_NEXT(a_hold_kept, hold_valid && !load, hold_valid, "waiting report dropped")
  `RFB_ASSERT_SAME(a_no_overrun, item_take, !hold_valid || load, "input register overwritten")
  `RFB_ASSERT_NEXT(a_load_empties, load && !item_take, !hold_valid, "loaded report still pending")

endmodule

/* dv/report_frame_builder_crc16_tb.sv */
// self-checking testbench for the report frame builder with crc-16/modbus
`timescale 1ns / 1ps

module report_frame_builder_crc16_tb;
  import rfb_pkg::*;

  localparam int NumDir     = 20;
  localparam int NumPhases  = 5;
  localparam int PerPhase   = 70;
  localparam int CycleLimit = 400000;
  localparam int HoldCycles = 300;

  // one expected frame byte, as the output channel carries it
  typedef struct packed {
    logic [7:0]      fbyte;
    logic [PosW-1:0] pos;
    logic            last;
  } frame_beat_t;

  // directed row: a report plus an optional byte typed in by hand
  typedef struct packed {
    item_t           rpt;
    logic            chk_en;
    logic [PosW-1:0] chk_pos;
    logic [7:0]      chk_val;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic            psel    = 1'b0;
  logic            penable = 1'b0;
  logic            pwrite  = 1'b0;
  logic [AddrW-1:0] paddr  = '0;
  logic [31:0]     pwdata  = '0;
  logic [31:0]     prdata;
  logic            pready;

  rfb_item_if report_ch ();
  rfb_byte_if frame_ch ();

  report_frame_builder_crc16 dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .item    (report_ch),
    .result  (frame_ch)
  );

  always #4 clk = ~clk;

  // register copy as the block should hold it, indexed by register
  logic [7:0] reg_shadow [7];
  // frame bytes still owed by the block, oldest first
  frame_beat_t pending_beats [$];

  int  mismatches = 0;
  int  cycles = 0;
  bit  calm = 1'b0;      // both sides skip their idle gaps while set
  bit  started = 1'b0;   // receiver runs only after reset

  // directed reports: extremes, byte patterns, every byte lane, many device codes
  dir_row_t dir_rows [NumDir] = '{
    // after reset the header and tail carry the register defaults
    '{'{8'h00, 32'h00000000, 32'h00000000, 16'h0000, 4'h0}, 1'b1, PosPayLen, 8'h0B},
    '{'{8'h00, 32'h00000000, 32'h00000000, 16'h0000, 4'h0}, 1'b1, PosVersion, 8'h01},
    '{'{8'h00, 32'h00000000, 32'h00000000, 16'h0000, 4'hB}, 1'b1, PosHdr0, 8'h00},
    '{'{8'h00, 32'h00000000, 32'h00000000, 16'h0000, 4'hD}, 1'b1, PosTail0, 8'h00},
    // every field at its top
    '{'{8'hFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 4'hF}, 1'b1, PosRaw3, 8'hFF},
    '{'{8'hFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 4'hF}, 1'b1, PosLast, 8'h00},
    // most negative and most positive raw samples
    '{'{8'h01, 32'h80000000, 32'h00000000, 16'h0000, 4'h1}, 1'b1, PosRaw3, 8'h80},
    '{'{8'h02, 32'h80000000, 32'h00000000, 16'h0000, 4'h2}, 1'b1, PosRaw0, 8'h00},
    '{'{8'h03, 32'h7FFFFFFF, 32'h00000000, 16'h0000, 4'h3}, 1'b1, PosRaw3, 8'h7F},
    '{'{8'h04, 32'h7FFFFFFF, 32'h00000000, 16'h0000, 4'h4}, 1'b1, PosRaw2, 8'hFF},
    '{'{8'h05, 32'h00000000, 32'hFFFFFFFF, 16'h0000, 4'h4}, 1'b1, PosWgt3, 8'hFF},
    // little-endian lane order
    '{'{8'h06, 32'h00000000, 32'h12345678, 16'h0000, 4'h5}, 1'b1, PosWgt0, 8'h78},
    '{'{8'h07, 32'h01020304, 32'h00000000, 16'h0000, 4'h6}, 1'b1, PosRaw1, 8'h03},
    '{'{8'h08, 32'h00000000, 32'h00000000, 16'hFFFF, 4'h7}, 1'b1, PosThr1, 8'hFF},
    '{'{8'h09, 32'h00000000, 32'h00000000, 16'h00FF, 4'h8}, 1'b1, PosThr1, 8'h00},
    '{'{8'hA5, 32'h00000000, 32'h00000000, 16'h0000, 4'h9}, 1'b1, PosSeq, 8'hA5},
    // alternating bit patterns, each followed by its complement
    '{'{8'h55, 32'hAAAAAAAA, 32'h55555555, 16'hAAAA, 4'hA}, 1'b1, PosDevice, 8'h0A},
    '{'{8'hAA, 32'h55555555, 32'hAAAAAAAA, 16'h5555, 4'h5}, 1'b1, PosThr0, 8'h55},
    // small negative sample, top device code
    '{'{8'h10, 32'hFFFFFF9C, 32'h00000064, 16'h03E8, 4'hF}, 1'b1, PosDevice, 8'h0F},
    '{'{8'h11, 32'h00000064, 32'h00000000, 16'h0001, 4'hE}, 1'b0, PosHdr0, 8'h00}
  };

  // first ten mismatches are shown, the rest only counted
  function automatic void flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch %0s: expected %0h, got %0h at cycle %0d", what, want, got, cycles);
    end
  endfunction

  // whole frame for one report under the current register settings
  function automatic void build_frame(input item_t rpt, output logic [7:0] fb [FrameLen]);
    logic [15:0] crc;
    fb[PosHdr0]    = reg_shadow[REG_HEADER_FIRST];
    fb[PosHdr1]    = reg_shadow[REG_HEADER_SECOND];
    fb[PosVersion] = reg_shadow[REG_PROTOCOL_VERSION];
    fb[PosMsgType] = reg_shadow[REG_MESSAGE_TYPE];
    fb[PosPayLen]  = reg_shadow[REG_PAYLOAD_LENGTH];
    fb[PosSeq]     = rpt.sequence_number;
    for (int k = 0; k < 4; k++) begin
      fb[PosRaw0 + k] = rpt.raw_sample[8*k +: 8];
      fb[PosWgt0 + k] = rpt.weight_tenths[8*k +: 8];
    end
    fb[PosThr0]   = rpt.threshold_grams[7:0];
    fb[PosThr1]   = rpt.threshold_grams[15:8];
    fb[PosDevice] = {4'h0, rpt.device_type};
    // crc covers version through device code, reflected, no final xor
    crc = 16'hFFFF;
    for (int k = PosVersion; k <= PosDevice; k++) begin
      crc = crc ^ {8'h00, fb[k]};
      repeat (8) crc = crc[0] ? ((crc >> 1) ^ 16'hA001) : (crc >> 1);
    end
    fb[PosCrcLo] = crc[7:0];
    fb[PosCrcHi] = crc[15:8];
    fb[PosTail0] = reg_shadow[REG_TAIL_FIRST];
    fb[PosLast]  = reg_shadow[REG_TAIL_SECOND];
  endfunction

  // offer one report after a random gap, then queue its frame once taken
  task automatic send_report(input item_t rpt, input logic chk_en,
                             input logic [PosW-1:0] chk_pos, input logic [7:0] chk_val);
    int gap;
    logic [7:0] fb [FrameLen];
    gap = calm ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      report_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    report_ch.valid           <= 1'b1;
    report_ch.sequence_number <= rpt.sequence_number;
    report_ch.raw_sample      <= rpt.raw_sample;
    report_ch.weight_tenths   <= rpt.weight_tenths;
    report_ch.threshold_grams <= rpt.threshold_grams;
    report_ch.device_type     <= rpt.device_type;
    @(posedge clk);
    while (!report_ch.ready) @(posedge clk);
    build_frame(rpt, fb);
    // hand-typed byte replaces the computed one
    if (chk_en) fb[chk_pos] = chk_val;
    for (int k = 0; k < FrameLen; k++) begin
      pending_beats.push_back('{fb[k], PosW'(k), (k == PosLast)});
    end
  endtask

  // drop valid and let the last frame drain before touching registers
  task automatic wait_idle();
    report_ch.valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // apb write, setup then access; bus is left driven until apb_park
  task automatic reg_write(input reg_idx_t idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    // out-of-range index must not land anywhere
    if (idx != REG_NONE) reg_shadow[idx] = data[7:0];
  endtask

  task automatic reg_read_check(input reg_idx_t idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[7:0] !== reg_shadow[idx]) begin
      flag_mismatch($sformatf("register %0s readback", idx.name()), reg_shadow[idx], prdata);
    end
  endtask

  task automatic apb_park();
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // load every register setting: phase 0 all zero, phase 1 all ones, else random;
  // upper data bits are junk that the block must drop
  task automatic load_settings(input int phase);
    logic [31:0] data;
    reg_idx_t idx;
    for (int r = REG_HEADER_FIRST; r <= REG_NONE; r++) begin
      idx = reg_idx_t'(r);
      data = $urandom;
      if (phase == 0) data[7:0] = 8'h00;
      else if (phase == 1) data[7:0] = 8'hFF;
      reg_write(idx, data);
    end
    for (int r = REG_HEADER_FIRST; r < REG_NONE; r++) begin
      reg_read_check(reg_idx_t'(r));
    end
    apb_park();
  endtask

  // random report, leaning toward extremes and small values now and then
  function automatic item_t random_report();
    item_t rpt;
    rpt.sequence_number = 8'($urandom);
    case ($urandom_range(0, 3))
      0: rpt.raw_sample = 32'($urandom_range(0, 200)) - 32'd100;
      1: begin
        case ($urandom_range(0, 3))
          0: rpt.raw_sample = 32'h80000000;
          1: rpt.raw_sample = 32'h7FFFFFFF;
          2: rpt.raw_sample = 32'hFFFFFFFF;
          default: rpt.raw_sample = 32'h0;
        endcase
      end
      default: rpt.raw_sample = $urandom;
    endcase
    rpt.weight_tenths   = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 100000))
                                                      : 32'($urandom);
    rpt.threshold_grams = 16'($urandom_range(0, 65535));
    rpt.device_type     = 4'($urandom_range(0, 15));
    return rpt;
  endfunction

  // frame byte checker, field by field against the oldest expectation
  always @(posedge clk) begin
    frame_beat_t want;
    if (!rst && frame_ch.valid && frame_ch.ready) begin
      if (pending_beats.size() == 0) begin
        flag_mismatch("frame byte with nothing expected", 0, frame_ch.frame_byte);
      end else begin
        want = pending_beats.pop_front();
        if (frame_ch.frame_byte !== want.fbyte) begin
          flag_mismatch($sformatf("frame_byte at position %0d", want.pos),
                        want.fbyte, frame_ch.frame_byte);
        end
        if (frame_ch.byte_position !== want.pos) begin
          flag_mismatch("byte_position", want.pos, frame_ch.byte_position);
        end
        if (frame_ch.last_byte !== want.last) begin
          flag_mismatch($sformatf("last_byte at position %0d", want.pos),
                        want.last, frame_ch.last_byte);
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: random stall before each transaction, two long hold-offs
  // so the block backs up and stops taking reports
  initial begin
    int stall;
    int taken;
    taken = 0;
    frame_ch.ready = 1'b0;
    wait (started);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 8);
      if (taken == 600 || taken == 4000) begin
        stall = HoldCycles;
      end
      if (stall > 0) begin
        frame_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      frame_ch.ready <= 1'b1;
      @(posedge clk);
      while (!frame_ch.valid) @(posedge clk);
      taken++;
    end
  end

  // stimulus
  initial begin
    report_ch.valid           = 1'b0;
    report_ch.sequence_number = '0;
    report_ch.raw_sample      = '0;
    report_ch.weight_tenths   = '0;
    report_ch.threshold_grams = '0;
    report_ch.device_type     = '0;
    reg_shadow = '{8'h00, 8'h00, 8'h01, 8'h00, 8'h0B, 8'h00, 8'h00};

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    started = 1'b1;

    // directed reports under the reset defaults
    for (int r = REG_HEADER_FIRST; r < REG_NONE; r++) begin
      reg_read_check(reg_idx_t'(r));
    end
    apb_park();
    foreach (dir_rows[i]) begin
      send_report(dir_rows[i].rpt, dir_rows[i].chk_en, dir_rows[i].chk_pos,
                  dir_rows[i].chk_val);
    end
    wait_idle();

    // random reports, new register settings per phase; the middle of each
    // phase runs back to back on both sides
    for (int ph = 0; ph < NumPhases; ph++) begin
      load_settings(ph);
      for (int n = 0; n < PerPhase; n++) begin
        calm = (n >= 25 && n < 45);
        send_report(random_report(), 1'b0, PosHdr0, 8'h00);
      end
      calm = 1'b0;
      wait_idle();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_beats.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
